FILE: sv/fpsm_pkg.sv
// ---------------------------------------------------------------------------
// fpsm_pkg
// Shared types and constants for the flash page status manager.
// ---------------------------------------------------------------------------
package fpsm_pkg;

  localparam int PAGE_BYTES       = 256;
  localparam int PAGES_PER_SECTOR = 256;
  localparam int SECTOR_COUNT     = 16;
  localparam int PAGES_PER_WORD   = 4;
  localparam int DEVICE_BYTES     = 1048576;
  localparam int TOTAL_PAGES      = SECTOR_COUNT * PAGES_PER_SECTOR;
  localparam int TABLE_WORDS      = (TOTAL_PAGES + PAGES_PER_WORD - 1) / PAGES_PER_WORD;
  localparam int SLOT_BITS        = 8 / PAGES_PER_WORD;
  localparam int WORDS_PER_SECTOR = PAGES_PER_SECTOR / PAGES_PER_WORD;
  localparam int WADDR_W          = $clog2(TABLE_WORDS);
  localparam int PAGE_SHIFT       = $clog2(PAGE_BYTES);
  localparam int PPW_SHIFT        = $clog2(PAGES_PER_WORD);
  localparam int PPS_SHIFT        = $clog2(PAGES_PER_SECTOR);
  localparam int SEC_W            = $clog2(SECTOR_COUNT) > 0 ? $clog2(SECTOR_COUNT) : 1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_VERIFY = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_STATE = 3'd1,
    ST_RANGE = 3'd2,
    ST_BAD   = 3'd3,
    ST_USED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_VRD,
    S_VWR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_ERASE_RD,
    S_ERASE_WR,
    S_PROG_RD,
    S_PROG_WR,
    S_DONE
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic cfg_we;
    logic mem_rd;     // issue read at current address
    logic ver_wr;     // write verify mark
    logic scan_init;  // set pointer to first page of span
    logic scan_chk;   // examine read word
    logic scan_step;  // advance pointer
    logic erase_init;
    logic erase_wr;
    logic erase_step;
    logic prog_wr;
    logic fin_ok;     // finalize successful write
    logic fin_rej;    // finalize rejected write
    logic out_load;
    logic out_take;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    shutdown;
    logic    range_bad;
    logic    empty;
    logic    bad_seen;
    logic    scan_last;
    logic    used_any;
    logic    erase_en;
    logic    erase_have;  // current sector selected for erase
    logic    erase_last;  // last word of current sector
    logic    erase_done;  // no more sectors
    logic    out_busy;
  } ctl_sts_t;

endpackage

FILE: sv/fpsm_ram.sv
// ---------------------------------------------------------------------------
// fpsm_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module fpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/fpsm_ctrl.sv
// ---------------------------------------------------------------------------
// fpsm_ctrl
// Sequencer for verify, range check, span scan, sector erase and program.
// ---------------------------------------------------------------------------
module fpsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  fpsm_pkg::ctl_sts_t sts,
  output fpsm_pkg::ctl_cmd_t cmd
);
  import fpsm_pkg::*;

  fsm_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (sts.shutdown && sts.op != OP_NONE) state_nxt = S_DONE;
        else if (sts.op == OP_VERIFY) state_nxt = S_VRD;
        else if (sts.op == OP_WRITE && !sts.range_bad && !sts.empty)
          state_nxt = S_SCAN_RD;
        else state_nxt = S_DONE;
      end
      S_VRD:      state_nxt = S_VWR;
      S_VWR:      state_nxt = S_DONE;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.bad_seen) state_nxt = S_DONE;
        else if (!sts.scan_last) state_nxt = S_SCAN_RD;
        else if (sts.used_any && !sts.erase_en) state_nxt = S_DONE;
        else if (sts.used_any) state_nxt = S_ERASE_RD;
        else state_nxt = S_PROG_RD;
      end
      S_ERASE_RD: begin
        if (sts.erase_done) state_nxt = S_PROG_RD;
        else if (sts.erase_have) state_nxt = S_ERASE_WR;
      end
      S_ERASE_WR: state_nxt = S_ERASE_RD;
      S_PROG_RD:  state_nxt = S_PROG_WR;
      S_PROG_WR:  state_nxt = sts.scan_last ? S_DONE : S_PROG_RD;
      S_DONE:     if (!sts.out_busy) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        // a register write never shares its edge with a new word
        in_ready  = 1'b1;
        cfg_ready = !in_valid;
        cmd.load  = in_valid;
        cmd.cfg_we = cfg_valid && !in_valid;
      end
      S_DECODE: begin
        if (state_nxt == S_SCAN_RD) cmd.scan_init = 1'b1;
        if (state_nxt == S_VRD) cmd.mem_rd = 1'b1;
      end
      S_VWR:      cmd.ver_wr = 1'b1;
      S_SCAN_RD:  cmd.mem_rd = 1'b1;
      S_SCAN_CHK: cmd.scan_chk = 1'b1;
      S_DECIDE: begin
        if (state_nxt == S_SCAN_RD) cmd.scan_step = 1'b1;
        if (state_nxt == S_ERASE_RD) cmd.erase_init = 1'b1;
        if (state_nxt == S_PROG_RD) cmd.scan_init = 1'b1;
        if (state_nxt == S_DONE) cmd.fin_rej = 1'b1;
      end
      S_ERASE_RD: begin
        if (state_nxt == S_PROG_RD) cmd.scan_init = 1'b1;
        else if (!sts.erase_have) cmd.erase_step = 1'b1;
        else cmd.mem_rd = 1'b1;
      end
      S_ERASE_WR: begin
        cmd.erase_wr   = 1'b1;
        cmd.erase_step = 1'b1;
      end
      S_PROG_RD:  cmd.mem_rd = 1'b1;
      S_PROG_WR: begin
        cmd.prog_wr = 1'b1;
        if (sts.scan_last) cmd.fin_ok = 1'b1;
        else cmd.scan_step = 1'b1;
      end
      S_DONE:     cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // only the idle state takes new words
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("input taken outside idle");
  a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accepted word not decoded");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |-> cmd.out_load)
    else $error("result dropped");

endmodule

FILE: sv/fpsm_dp.sv
// ---------------------------------------------------------------------------
// fpsm_dp
// Datapath: request registers, range math, status table, result register.
// ---------------------------------------------------------------------------
module fpsm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  fpsm_pkg::ctl_cmd_t cmd,
  output fpsm_pkg::ctl_sts_t sts,
  input  logic               cfg_erase_enable,
  input  logic [1:0]         in_opcode,
  input  logic [23:0]        in_address,
  input  logic [15:0]        in_length,
  input  logic               in_allow_clip,
  input  logic               in_abnormal_shutdown,
  input  logic [11:0]        in_page_index,
  input  logic               in_page_matched,
  input  logic               in_overwrite,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [15:0]        out_granted_length,
  output logic [15:0]        out_erase_mask,
  output logic               out_program_needed,
  output logic [11:0]        out_first_page,
  output logic [11:0]        out_last_page,
  output logic [7:0]         out_first_offset,
  output logic [8:0]         out_last_end
);
  import fpsm_pkg::*;

  localparam logic [24:0] DEV = 25'(DEVICE_BYTES);

  // captured request
  opcode_t     op_r;
  logic [23:0] addr_r;
  logic [15:0] len_r;
  logic        clip_r, shut_r, match_r, ovw_r;
  logic [11:0] pidx_r;
  logic        erase_en_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode_t'(in_opcode);
      addr_r  <= in_address;
      len_r   <= in_length;
      clip_r  <= in_allow_clip;
      shut_r  <= in_abnormal_shutdown;
      pidx_r  <= in_page_index;
      match_r <= in_page_matched;
      ovw_r   <= in_overwrite;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_en_r <= 1'b0;
    end else if (cmd.cfg_we) begin
      erase_en_r <= cfg_erase_enable;
    end
  end

  // range check and clipping
  logic [24:0] end_x;
  logic        addr_oob, over;
  logic [15:0] glen;
  logic [24:0] last_b;
  logic [11:0] pb, pe;
  always_comb begin
    end_x    = {1'b0, addr_r} + 25'(len_r);
    addr_oob = {1'b0, addr_r} >= DEV;
    over     = end_x > DEV;
    glen     = over ? 16'(DEV - {1'b0, addr_r}) : len_r;
    last_b   = {1'b0, addr_r} + 25'(glen) - 25'd1;
    pb       = 12'(addr_r >> PAGE_SHIFT);
    pe       = 12'(last_b >> PAGE_SHIFT);
  end
  wire range_bad = addr_oob || (over && !clip_r);

  // scan pointer over pages and words
  logic [12:0] pg_r, pg_nxt;
  logic        bad_r, used_r;
  logic [SECTOR_COUNT-1:0] secs_r;
  logic [SEC_W-1:0]        sec_r;
  logic [PPS_SHIFT-PPW_SHIFT-1:0] woff_r;
  logic [WADDR_W-1:0] ram_addr;
  logic               ram_we;
  logic [7:0]         ram_wd, ram_rd;

  // slot position of the current page
  logic [PPW_SHIFT:0] slot_i;
  logic [2:0]         sh;
  logic [1:0]         slot_v;
  always_comb begin
    slot_i = (PPW_SHIFT + 1)'(PAGES_PER_WORD - 1) - (PPW_SHIFT + 1)'(pg_r[PPW_SHIFT-1:0]);
    sh     = 3'(slot_i * SLOT_BITS);
    slot_v = 2'(ram_rd >> sh);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      pg_r <= cmd.fin_ok ? pg_r : {1'b0, pb};
    end else if (cmd.scan_step) begin
      pg_r <= pg_r + 13'd1;
    end else if (cmd.load) begin
      pg_r <= {1'b0, in_page_index};
    end
    if (cmd.load) begin
      bad_r  <= 1'b0;
      used_r <= 1'b0;
      secs_r <= '0;
    end else if (cmd.scan_chk) begin
      if (pg_r >= 13'(TOTAL_PAGES) || !slot_v[0]) begin
        bad_r <= 1'b1;
      end else if (!slot_v[1]) begin
        used_r <= 1'b1;
        secs_r[SEC_W'(pg_r >> PPS_SHIFT)] <= 1'b1;
      end
    end
    if (cmd.erase_init) begin
      sec_r  <= '0;
      woff_r <= '0;
    end else if (cmd.erase_step) begin
      if (!secs_r[sec_r] || &woff_r) begin
        sec_r  <= sec_r + SEC_W'(1);
        woff_r <= '0;
      end else begin
        woff_r <= woff_r + 1'b1;
      end
    end
  end

  // erase pass done once the sector counter wraps past the last sector
  logic erase_done_r;
  always_ff @(posedge clk) begin
    if (cmd.erase_init) begin
      erase_done_r <= 1'b0;
    end else if (cmd.erase_step && (sec_r == SEC_W'(SECTOR_COUNT - 1))
                 && (!secs_r[sec_r] || &woff_r)) begin
      erase_done_r <= 1'b1;
    end
  end

  // RAM address and write data
  logic erasing_r;
  always_ff @(posedge clk) begin
    if (cmd.erase_init) erasing_r <= 1'b1;
    else if (cmd.scan_init || cmd.load) erasing_r <= 1'b0;
  end

  logic [7:0] free_all;
  always_comb begin
    free_all = '0;
    for (int i = 0; i < PAGES_PER_WORD; i++) begin
      free_all[i*SLOT_BITS+1] = 1'b1;
    end
  end

  logic [1:0] vmark;
  always_comb begin
    if (erasing_r) begin
      ram_addr = WADDR_W'({sec_r, woff_r});
    end else begin
      ram_addr = WADDR_W'(pg_r >> PPW_SHIFT);
    end
    vmark  = {1'b1, match_r};
    if (!ovw_r) vmark = vmark & slot_v;
    ram_we = 1'b0;
    ram_wd = ram_rd;
    if (cmd.ver_wr && pg_r < 13'(TOTAL_PAGES)) begin
      ram_we = 1'b1;
      ram_wd = (ram_rd & ~(8'(2'b11) << sh)) | (8'(vmark) << sh);
    end else if (cmd.erase_wr) begin
      ram_we = 1'b1;
      ram_wd = ram_rd | free_all;
    end else if (cmd.prog_wr) begin
      ram_we = 1'b1;
      ram_wd = ram_rd & ~(8'(2'b10) << sh);
    end
  end

  fpsm_ram #(.WIDTH(8), .DEPTH(TABLE_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  // result register
  logic        ov_r;
  status_t     st_r;
  logic [15:0] gl_r, em_r;
  logic        pn_r;
  logic [11:0] fp_r, lp_r;
  logic [7:0]  fo_r;
  logic [8:0]  le_r;
  logic        rej_r, ok_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rej_r <= 1'b0;
      ok_r  <= 1'b0;
    end else if (cmd.fin_rej) begin
      rej_r <= 1'b1;
    end else if (cmd.fin_ok) begin
      ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      st_r <= ST_OK;
      gl_r <= '0;
      em_r <= '0;
      pn_r <= 1'b0;
      fp_r <= '0;
      lp_r <= '0;
      fo_r <= '0;
      le_r <= '0;
      if (shut_r && op_r != OP_NONE) begin
        st_r <= ST_STATE;
      end else if (op_r == OP_WRITE || op_r == OP_READ) begin
        if (range_bad) begin
          st_r <= ST_RANGE;
        end else begin
          gl_r <= glen;
          if (rej_r) begin
            st_r <= bad_r ? ST_BAD : ST_USED;
          end else if (ok_r) begin
            em_r <= 16'(secs_r);
            pn_r <= 1'b1;
            fp_r <= pb;
            lp_r <= pe;
            fo_r <= 8'(addr_r[PAGE_SHIFT-1:0]);
            le_r <= 9'({1'b0, last_b[PAGE_SHIFT-1:0]} + 9'd1);
          end
        end
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = st_r;
  assign out_granted_length = gl_r;
  assign out_erase_mask     = em_r;
  assign out_program_needed = pn_r;
  assign out_first_page     = fp_r;
  assign out_last_page      = lp_r;
  assign out_first_offset   = fo_r;
  assign out_last_end       = le_r;

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.shutdown   = shut_r;
    sts.range_bad  = range_bad;
    sts.empty      = glen == 16'd0;
    sts.bad_seen   = bad_r;
    sts.scan_last  = pg_r[11:0] == pe;
    sts.used_any   = used_r;
    sts.erase_en   = erase_en_r;
    sts.erase_have = secs_r[sec_r] && !erase_done_r;
    sts.erase_last = &woff_r;
    sts.erase_done = erase_done_r;
    sts.out_busy   = ov_r && !out_ready;
  end

  a_ok_prog: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r != ST_OK) |-> !pn_r)
    else $error("program flagged on failed request");
  a_rej_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !pn_r) |-> em_r == 16'd0)
    else $error("erase mask on non-programmed result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r)
    else $error("result lost while stalled");

endmodule

FILE: sv/flash_page_status_manager.sv
// ---------------------------------------------------------------------------
// flash_page_status_manager
// Good and free marks per flash page with range check, erase and program.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid / in_ready     | opcode .. overwrite
//  out     | out_valid / out_ready   | status .. last_end
//  cfg     | cfg_valid / cfg_ready   | cfg_erase_enable
//
// One item at a time. A verify reads the table word and writes its mark back; reads
// and requests refused at decode go straight to done. A write scans each page of its
// span (read, check, decide), then programs each page (read, write); when sectors are
// erased, it first reads and rewrites each word of each erased sector (64 words), all
// through the single port of the status RAM. Reset clears control only; table words
// are defined by verify items. A stalled result holds the block.
module flash_page_status_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [23:0] in_address,
  input  logic [15:0] in_length,
  input  logic        in_allow_clip,
  input  logic        in_abnormal_shutdown,
  input  logic [11:0] in_page_index,
  input  logic        in_page_matched,
  input  logic        in_overwrite,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_length,
  output logic [15:0] out_erase_mask,
  output logic        out_program_needed,
  output logic [11:0] out_first_page,
  output logic [11:0] out_last_page,
  output logic [7:0]  out_first_offset,
  output logic [8:0]  out_last_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_erase_enable
);
  import fpsm_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  fpsm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .cfg_valid, .cfg_ready,
    .sts (sts), .cmd (cmd)
  );

  fpsm_dp u_dp (
    .clk, .rst_n, .cmd (cmd), .sts (sts), .cfg_erase_enable,
    .in_opcode, .in_address, .in_length, .in_allow_clip,
    .in_abnormal_shutdown, .in_page_index, .in_page_matched, .in_overwrite,
    .out_valid, .out_ready, .out_status, .out_granted_length,
    .out_erase_mask, .out_program_needed, .out_first_page, .out_last_page,
    .out_first_offset, .out_last_end
  );

endmodule
